// ===== sv/abd_pkg.sv =====
// abd_pkg: shared types, constants and GF(2^8) helpers for the AES block decrypt.
// No dependencies.
`timescale 1ns / 1ps
package abd_pkg;

   localparam int unsigned MIN_ROUNDS = 10;
   localparam int unsigned WORD_W     = 64;
   localparam int unsigned SLOT_W     = 5;

   typedef enum logic {
      MODE_LOAD    = 1'b0,
      MODE_DECRYPT = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIRST,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef logic [7:0] byte_type;

   function automatic byte_type inv_sbox(input byte_type a);
      byte_type r;
      r = 8'h00;
      case (a)
         8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
         8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
         8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
         8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
         8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
         8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
         8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
         8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
         8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
         8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
         8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
         8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
         8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
         8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
         8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
         8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
         8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
         8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
         8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
         8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
         8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
         8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
         8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
         8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
         8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
         8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
         8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
         8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
         8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
         8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
         8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
         8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
         8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
         8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
         8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
         8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
         8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
         8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
         8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
         8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
         8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
         8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
         8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
         8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
         8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
         8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
         8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
         8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
         8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
         8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
         8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
         8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
         8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
         8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
         8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
         8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
         8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
         8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
         8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
         8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
         8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
         8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
         8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
         8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type xtime(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // x9, xb, xd, xe built from doublings
   function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
      byte_type a [4];
      byte_type a2 [4];
      byte_type a4 [4];
      byte_type a8 [4];
      byte_type m9 [4];
      byte_type mb [4];
      byte_type md [4];
      byte_type me [4];
      logic [31:0] r;
      for (int i = 0; i < 4; i++) begin
         a[i]  = c[8*i +: 8];
         a2[i] = xtime(a[i]);
         a4[i] = xtime(a2[i]);
         a8[i] = xtime(a4[i]);
         m9[i] = a8[i] ^ a[i];
         mb[i] = a8[i] ^ a2[i] ^ a[i];
         md[i] = a8[i] ^ a4[i] ^ a[i];
         me[i] = a8[i] ^ a4[i] ^ a2[i];
      end
      r[7:0]   = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      r[15:8]  = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      r[23:16] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      r[31:24] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      return r;
   endfunction

   // InvShiftRows, inverse S-box and optional InvMixColumns on a 128-bit state
   function automatic logic [127:0] inv_round(input logic [127:0] s, input logic mix);
      logic [127:0] t;
      logic [127:0] m;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(r + 4*c) +: 8] = inv_sbox(s[8*(r + 4*((c + 4 - r) % 4)) +: 8]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         m[32*c +: 32] = inv_mix_col(t[32*c +: 32]);
      end
      return mix ? m : t;
   endfunction

endpackage

// ===== sv/abd_if.sv =====
// abd_if: valid/ready channel interfaces for request, response and CSR write.
// Depends on nothing.
`timescale 1ns / 1ps
interface abd_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [4:0]  key_slot;
   logic [63:0] word_lo;
   logic [63:0] word_hi;
   modport source (output valid, mode, key_slot, word_lo, word_hi, input ready);
   modport sink (input valid, mode, key_slot, word_lo, word_hi, output ready);
endinterface

interface abd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] plain_lo;
   logic [63:0] plain_hi;
   modport source (output valid, plain_lo, plain_hi, input ready);
   modport sink (input valid, plain_lo, plain_hi, output ready);
endinterface

interface abd_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== sv/aes_block_decrypt.sv =====
// Throughput: one decrypt item at a time, one round per cycle in the shared round unit;
// a new decrypt item is taken only in the idle state. The round-key memory
// (one read port, two 64-bit halves) supplies one key per cycle. A held response stalls
// the sequencer only in its last state. Key load items leave the sequencer idle.
// Reset clears control state and sets rounds to 10; round keys are undefined until loaded.
// Depends on abd_pkg and abd_if.
`timescale 1ns / 1ps
module aes_block_decrypt #(
   parameter int unsigned MAX_ROUNDS = 14
) (
   input logic clock,
   input logic reset,
   abd_req_if.sink   req,
   abd_rsp_if.source rsp,
   abd_csr_if.sink   csr
);
   localparam int unsigned SLOTS = 2 * (MAX_ROUNDS + 1);
   localparam int unsigned RW    = $clog2(MAX_ROUNDS + 1);

   // two half memories, indexed by round
   logic [63:0] key_lo_mem [MAX_ROUNDS + 1];
   logic [63:0] key_hi_mem [MAX_ROUNDS + 1];
   logic [63:0] key_lo_ff, key_hi_ff;

   abd_pkg::state_type state_ff, state_in;
   logic [3:0]   rounds_ff;
   logic [RW-1:0] rnd_ff, rnd_in, rd_addr;
   logic [127:0] st_ff, st_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] out_ff;
   logic         accept, do_load, do_dec, done_go;
   logic [RW-1:0] n_clamp;
   logic [127:0] keyed;

   assign csr.ready = 1'b1;
   assign accept  = req.valid && req.ready;
   assign do_load = accept && (req.mode == abd_pkg::MODE_LOAD);
   assign do_dec  = accept && (req.mode == abd_pkg::MODE_DECRYPT);
   // last state hands the block to the output register once it is free
   assign done_go = (state_ff == abd_pkg::ST_DONE) && (!rsp_valid_ff || rsp.ready);

   // clamp round count
   always_comb begin
      if (rounds_ff < 4'(abd_pkg::MIN_ROUNDS))
         n_clamp = RW'(abd_pkg::MIN_ROUNDS);
      else if (32'(rounds_ff) > MAX_ROUNDS)
         n_clamp = RW'(MAX_ROUNDS);
      else
         n_clamp = RW'(rounds_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) rounds_ff <= 4'd10;
      else if (csr.valid) rounds_ff <= csr.data;
   end

   // key memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (do_load && 32'(req.key_slot) < SLOTS) begin
         if (req.key_slot[0]) key_hi_mem[req.key_slot[RW:1]] <= req.word_lo;
         else key_lo_mem[req.key_slot[RW:1]] <= req.word_lo;
      end
      key_lo_ff <= key_lo_mem[rd_addr];
      key_hi_ff <= key_hi_mem[rd_addr];
   end

   assign keyed = st_ff ^ {key_hi_ff, key_lo_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rd_addr      = rnd_ff;
      req.ready    = 1'b0;
      unique case (state_ff)
         abd_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            rd_addr   = n_clamp;
            if (do_dec) begin
               st_in    = {req.word_hi, req.word_lo};
               rnd_in   = n_clamp - RW'(1);
               state_in = abd_pkg::ST_FIRST;
            end
         end
         abd_pkg::ST_FIRST: begin
            // last round key arrives now
            st_in    = keyed;
            state_in = abd_pkg::ST_ROUND;
         end
         abd_pkg::ST_ROUND: begin
            // key for this round is in the read register; fetch the next one
            st_in   = abd_pkg::inv_round(st_ff, rnd_ff != '0) ^ {key_hi_ff, key_lo_ff};
            rd_addr = (rnd_ff == '0) ? '0 : rnd_ff - RW'(1);
            if (rnd_ff == '0) state_in = abd_pkg::ST_DONE;
            else rnd_in = rnd_ff - RW'(1);
         end
         abd_pkg::ST_DONE: begin
            if (done_go) begin
               rsp_valid_in = 1'b1;
               state_in     = abd_pkg::ST_IDLE;
            end
         end
         default: state_in = abd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rnd_ff <= rnd_in;
      st_ff  <= st_in;
      if (done_go) out_ff <= st_ff;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.plain_lo = out_ff[63:0];
   assign rsp.plain_hi = out_ff[127:64];

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != abd_pkg::ST_IDLE) |-> !req.ready) else $error("accept while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abd_pkg::ST_DONE) |=> rsp_valid_ff) else $error("no response");
   a_dec_starts: assert property (@(posedge clock) disable iff (reset)
      do_dec |=> (state_ff == abd_pkg::ST_FIRST)) else $error("decrypt not started");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> $stable(out_ff)) else $error("response changed");
endmodule
